// ===== design/nnlt_pkg.sv =====
package nnlt_pkg;

  // Fixed port widths of the block.
  localparam int KindW    = 2;
  localparam int PtW      = 11;
  localparam int NbW      = 11;
  localparam int DistOutW = 32;

  // Reset value of the active point count.
  localparam logic [PtW-1:0] ActiveReset = 11'd1024;

  // Item kinds.
  localparam logic [KindW-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KindW-1:0] KIND_INSERT = 2'd1;
  localparam logic [KindW-1:0] KIND_QUERY  = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_LOAD,
    ST_SCAN,
    ST_OUT
  } state_t;

endpackage

// ===== design/nnlt_row_mem.sv =====
module nnlt_row_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int W     = 258
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/nnlt_slot_scan.sv =====
module nnlt_slot_scan #(
  parameter int NEIGHBOURS = 6,
  parameter int DIST_BITS  = 32,
  localparam int PosW = $clog2(NEIGHBOURS + 1),
  localparam int SelW = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  logic [NEIGHBOURS-1:0][DIST_BITS-1:0]  dists,
  input  logic [DIST_BITS-1:0]                  cand,
  output logic                                  done,
  output logic [PosW-1:0]                       pos
);

  logic            busy_r;
  logic            done_r;
  logic [PosW-1:0] idx_r;
  logic [PosW-1:0] pos_r;
  logic            less;
  logic            last;

  // One comparator walks the slots from rank one upward.
  always_comb begin
    less = dists[idx_r[SelW-1:0]] < cand;
    last = idx_r == PosW'(NEIGHBOURS - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (!less || last)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      idx_r <= '0;
    end else if (busy_r) begin
      if (!less) begin
        pos_r <= idx_r;
      end else if (last) begin
        pos_r <= PosW'(NEIGHBOURS);
      end else begin
        idx_r <= idx_r + PosW'(1);
      end
    end
  end

  assign done = done_r;
  assign pos  = pos_r;

endmodule

// ===== design/nearest_neighbour_list_table_core.sv =====
// Channel  Direction  Handshake           Beat contents
// in       input      in_valid/in_stall   kind, point_index, second_index, distance
// out      output     out_valid/out_stall kept, found, neighbour_point, neighbour_distance,
//                                         index_error
// cfg      input      cfg_valid/cfg_ready active_points
//
// Every input beat gives exactly one output beat, and the block takes one beat at a time.
// A rejected beat (bad index or unused kind) goes straight to the output state, a query reads
// its row and then outputs, an insert reads its row, scans at most NEIGHBOURS slots with the single
// distance comparator and then outputs, and a clear writes min(active_points, MAX_POINTS) rows,
// one row written per cycle through the single write port of the row memory.
// After reset the block sweeps all MAX_POINTS rows, one a cycle, before it takes a beat.
// Configuration beats are taken at any time; in_stall is high whenever the block is busy,
// and a stalled output beat holds the block until it is taken.
module nearest_neighbour_list_table_core #(
  parameter int MAX_POINTS = 1024,
  parameter int NEIGHBOURS = 6,
  parameter int DIST_BITS  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [nnlt_pkg::KindW-1:0]    in_kind,
  input  logic [nnlt_pkg::PtW-1:0]      in_point_index,
  input  logic [nnlt_pkg::PtW-1:0]      in_second_index,
  input  logic [nnlt_pkg::DistOutW-1:0] in_distance,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kept,
  output logic                          out_found,
  output logic [nnlt_pkg::NbW-1:0]      out_neighbour_point,
  output logic [nnlt_pkg::DistOutW-1:0] out_neighbour_distance,
  output logic                          out_index_error,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nnlt_pkg::PtW-1:0]      cfg_active_points
);

  localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CntW  = $clog2(MAX_POINTS + 1);
  localparam int IdxW  = (AW > nnlt_pkg::PtW) ? AW : nnlt_pkg::PtW;
  localparam int SlotW = nnlt_pkg::NbW + DIST_BITS;
  localparam int RowW  = NEIGHBOURS * SlotW;
  localparam int PosW  = $clog2(NEIGHBOURS + 1);
  localparam int SelW  = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;
  localparam int ExtW  = (DIST_BITS > nnlt_pkg::DistOutW) ? DIST_BITS : nnlt_pkg::DistOutW;

  nnlt_pkg::state_t state_r, state_nxt;

  logic [nnlt_pkg::PtW-1:0]   active_points_r;

  // Item held while it is worked on.
  logic [nnlt_pkg::KindW-1:0] kind_r;
  logic [AW-1:0]              row_r;
  logic [nnlt_pkg::NbW-1:0]   nb_r;
  logic [DIST_BITS-1:0]       dist_r;
  logic [SelW-1:0]            rank_r;
  logic [CntW-1:0]            cnt_r;
  logic [CntW-1:0]            end_r;

  // Result register.
  logic                          kept_r;
  logic                          found_r;
  logic [nnlt_pkg::NbW-1:0]      nbp_r;
  logic [nnlt_pkg::DistOutW-1:0] nbd_r;
  logic                          err_r;

  // Row memory and scanner wiring.
  logic                                   mem_we;
  logic                                   mem_re;
  logic [AW-1:0]                          mem_waddr;
  logic [RowW-1:0]                        mem_wdata;
  logic [RowW-1:0]                        rd_row;
  logic [NEIGHBOURS-1:0][SlotW-1:0]       rd_slots;
  logic [NEIGHBOURS-1:0][SlotW-1:0]       ins_slots;
  logic [NEIGHBOURS-1:0][SlotW-1:0]       empty_slots;
  logic [NEIGHBOURS-1:0][DIST_BITS-1:0]   rd_dists;
  logic                                   scan_start;
  logic                                   scan_done;
  logic [PosW-1:0]                        scan_pos;

  // Decode of the incoming beat.
  logic                      accept;
  logic                      point_ok;
  logic                      ins_ok;
  logic                      qry_ok;
  logic                      in_err;
  logic [31:0]               lim_wide;
  logic [CntW-1:0]           lim;
  logic [IdxW-1:0]           pidx_m1;
  logic [nnlt_pkg::PtW-1:0]  sidx_m1;
  logic [ExtW-1:0]           cand_ext;
  logic                      wipe_last;

  // Query slot view.
  logic [SlotW-1:0]          q_slot;
  logic [nnlt_pkg::NbW-1:0]  q_nb;
  logic [ExtW-1:0]           q_dist_ext;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_points_r <= nnlt_pkg::ActiveReset;
    end else if (cfg_valid && cfg_ready) begin
      active_points_r <= cfg_active_points;
    end
  end

  // The effective point count is the register bounded by the table size.
  always_comb begin
    accept   = in_valid && !in_stall;
    lim_wide = (32'(active_points_r) <= 32'(MAX_POINTS)) ? 32'(active_points_r)
                                                         : 32'(MAX_POINTS);
    lim      = lim_wide[CntW-1:0];
    point_ok = (in_point_index != '0) && (in_point_index <= active_points_r)
               && (32'(in_point_index) <= 32'(MAX_POINTS));
    ins_ok   = point_ok && (in_second_index != '0)
               && (32'(in_second_index) <= 32'(MAX_POINTS));
    qry_ok   = point_ok && (in_second_index != '0)
               && (32'(in_second_index) <= 32'(NEIGHBOURS));
    case (in_kind)
      nnlt_pkg::KIND_INSERT: in_err = !ins_ok;
      nnlt_pkg::KIND_QUERY:  in_err = !qry_ok;
      default:               in_err = 1'b0;
    endcase
    pidx_m1   = IdxW'(in_point_index) - IdxW'(1);
    sidx_m1   = in_second_index - nnlt_pkg::PtW'(1);
    cand_ext  = ExtW'(in_distance);
    wipe_last = cnt_r == (end_r - CntW'(1));
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nnlt_pkg::ST_INIT: begin
        if (wipe_last) begin
          state_nxt = nnlt_pkg::ST_IDLE;
        end
      end
      nnlt_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            nnlt_pkg::KIND_CLEAR:
              state_nxt = (lim == '0) ? nnlt_pkg::ST_OUT : nnlt_pkg::ST_CLEAR;
            nnlt_pkg::KIND_INSERT,
            nnlt_pkg::KIND_QUERY:
              state_nxt = in_err ? nnlt_pkg::ST_OUT : nnlt_pkg::ST_LOAD;
            default:
              state_nxt = nnlt_pkg::ST_OUT;
          endcase
        end
      end
      nnlt_pkg::ST_CLEAR: begin
        if (wipe_last) begin
          state_nxt = nnlt_pkg::ST_OUT;
        end
      end
      nnlt_pkg::ST_LOAD: begin
        state_nxt = (kind_r == nnlt_pkg::KIND_INSERT) ? nnlt_pkg::ST_SCAN
                                                      : nnlt_pkg::ST_OUT;
      end
      nnlt_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = nnlt_pkg::ST_OUT;
        end
      end
      nnlt_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_nxt = nnlt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = nnlt_pkg::ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nnlt_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Row views: slot k holds the neighbour number above its distance.
  always_comb begin
    rd_slots = rd_row;
    for (int k = 0; k < NEIGHBOURS; k++) begin
      rd_dists[k]    = rd_slots[k][DIST_BITS-1:0];
      empty_slots[k] = {{nnlt_pkg::NbW{1'b0}}, {DIST_BITS{1'b1}}};
      // The candidate goes in at the scan position and pushes the tail down by one.
      if (PosW'(k) < scan_pos) begin
        ins_slots[k] = rd_slots[k];
      end else if (PosW'(k) == scan_pos) begin
        ins_slots[k] = {nb_r, dist_r};
      end else begin
        ins_slots[k] = rd_slots[(k > 0) ? k - 1 : 0];
      end
    end
    q_slot     = rd_slots[rank_r];
    q_nb       = q_slot[SlotW-1:DIST_BITS];
    q_dist_ext = ExtW'(q_slot[DIST_BITS-1:0]);
  end

  // Sequencer outputs.
  always_comb begin
    in_stall   = state_r != nnlt_pkg::ST_IDLE;
    out_valid  = state_r == nnlt_pkg::ST_OUT;
    mem_re     = accept;
    scan_start = (state_r == nnlt_pkg::ST_LOAD) && (kind_r == nnlt_pkg::KIND_INSERT);
    mem_we     = 1'b0;
    mem_waddr  = cnt_r[AW-1:0];
    mem_wdata  = empty_slots;
    case (state_r)
      nnlt_pkg::ST_INIT,
      nnlt_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
      end
      nnlt_pkg::ST_SCAN: begin
        mem_we    = scan_done && (scan_pos < PosW'(NEIGHBOURS));
        mem_waddr = row_r;
        mem_wdata = ins_slots;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sweep counter; the reset pass covers the whole table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      end_r <= CntW'(MAX_POINTS);
    end else if (accept) begin
      cnt_r <= '0;
      end_r <= lim;
    end else if ((state_r == nnlt_pkg::ST_INIT) || (state_r == nnlt_pkg::ST_CLEAR)) begin
      cnt_r <= cnt_r + CntW'(1);
    end
  end

  // Item fields and result.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_kind;
      row_r   <= pidx_m1[AW-1:0];
      nb_r    <= in_second_index;
      dist_r  <= cand_ext[DIST_BITS-1:0];
      rank_r  <= sidx_m1[SelW-1:0];
      kept_r  <= 1'b0;
      found_r <= 1'b0;
      nbp_r   <= '0;
      err_r   <= in_err;
      nbd_r   <= ((in_kind == nnlt_pkg::KIND_QUERY) && in_err) ? '1 : '0;
    end else if ((state_r == nnlt_pkg::ST_LOAD) && (kind_r == nnlt_pkg::KIND_QUERY)) begin
      // A slot counts as filled when its neighbour number is nonzero.
      found_r <= q_nb != '0;
      nbp_r   <= q_nb;
      nbd_r   <= (q_nb != '0) ? q_dist_ext[nnlt_pkg::DistOutW-1:0] : '1;
    end else if ((state_r == nnlt_pkg::ST_SCAN) && scan_done) begin
      kept_r  <= scan_pos < PosW'(NEIGHBOURS);
    end
  end

  assign out_kept               = kept_r;
  assign out_found              = found_r;
  assign out_neighbour_point    = nbp_r;
  assign out_neighbour_distance = nbd_r;
  assign out_index_error        = err_r;

  nnlt_row_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW),
    .W     (RowW)
  ) u_row_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (pidx_m1[AW-1:0]),
    .rdata (rd_row)
  );

  nnlt_slot_scan #(
    .NEIGHBOURS (NEIGHBOURS),
    .DIST_BITS  (DIST_BITS)
  ) u_slot_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .dists (rd_dists),
    .cand  (dist_r),
    .done  (scan_done),
    .pos   (scan_pos)
  );

  // The table is never written while a result beat is offered.
  a_no_write_on_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !mem_we)
    else $error("row written while result pending");

  // The scanner only finishes while the sequencer waits for it.
  a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |-> (state_r == nnlt_pkg::ST_SCAN))
    else $error("scan finished outside scan state");

  // A sweep never writes past its end row.
  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == nnlt_pkg::ST_INIT) || (state_r == nnlt_pkg::ST_CLEAR)) |-> (cnt_r < end_r))
    else $error("sweep past end row");

  // A kept candidate never comes with an index error.
  a_kept_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_kept && out_index_error))
    else $error("kept with index error");

  // An empty query result carries no neighbour number.
  a_empty_query: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_neighbour_point == '0))
    else $error("neighbour reported for empty slot");

endmodule
